// ===== rtl/sorted_list_insert_remove_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted list assertion macros
// Shared property forms for the sorted list block.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SLI_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("sorted list: same-cycle check failed");

// next-cycle implication, disabled in reset
`define SLI_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("sorted list: next-cycle check failed");

`endif

// ===== rtl/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list package
// Command codes and compare result type for the sorted list block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIND   = 2'd2
	} cmd_t;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned FIELD_W = 5;

	typedef struct packed {
		logic precedes;
		logic equal;
	} cmp_res_t;

endpackage

`default_nettype wire

// ===== rtl/sli_cmp.sv =====
// ----------------------------------------------------------------------------
// Sorted list compare unit
// Signed order and equality test of one stored entry against the key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sli_cmp
	import sli_pkg::*;
(
	input  wire logic               descending,
	input  wire logic [VALUE_W-1:0] entry,
	input  wire logic [VALUE_W-1:0] key,
	output cmp_res_t                res
);

	logic less;
	logic greater;

	assign less    = $signed(entry) < $signed(key);
	assign greater = $signed(entry) > $signed(key);

	assign res.precedes = descending ? greater : less;
	assign res.equal    = (entry == key);

endmodule

`default_nettype wire

// ===== rtl/sorted_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// Sorted list insert / remove
// Bounded list of distinct signed values kept in ascending or descending
// order; insert, remove and find commands with one result each.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  command   start, busy             cmd, value
//  result    done (one-cycle strobe) ok, present, position, count
//  config    cfg_valid, cfg_ready    cfg_data (order: 0 ascending, 1 descending)
//
//  busy holds while the search reads and compares the entries in order, up to
//  the first one not ordered before the value or past the last one; when an
//  insert or remove changes the list, each entry shifted is read and then
//  written, and a last step updates the count (an insert writes the value).
//  The entry memory serves one read or one write at a time; one compare unit.
//  Reset clears the entry count and order; entries need no clearing.
//  done pulses for one cycle as busy falls; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_insert_remove_defines.svh"

module sorted_list_insert_remove
	import sli_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         cmd,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    done,
	output logic                    ok,
	output logic                    present,
	output logic [FIELD_W-1:0]      position,
	output logic [FIELD_W-1:0]      count,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CMP,
		S_DECIDE,
		S_INS,
		S_INS_WR,
		S_REM,
		S_REM_WR
	} state_t;

	state_t               state_q;
	logic [1:0]           cmd_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 order_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     pos_q;
	logic                 found_q;
	logic                 ok_q;
	logic                 done_q;

	logic [VALUE_W-1:0]   mem_q [CAPACITY];
	logic [VALUE_W-1:0]   rd_data_q;

	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [VALUE_W-1:0]   wr_data;

	logic                 scan_more;
	logic                 ins_more;
	logic                 rem_more;
	logic                 has_room;
	logic [CNT_W-1:0]     ptr_dec;
	logic [CNT_W:0]       ptr_inc;
	cmp_res_t             cmp_res;
	logic [31:0]          pos_wide;
	logic [31:0]          cnt_wide;

	sli_cmp u_cmp (
		.descending (order_q),
		.entry      (rd_data_q),
		.key        (value_q),
		.res        (cmp_res)
	);

	assign ptr_dec   = ptr_q - CNT_W'(1);
	assign ptr_inc   = {1'b0, ptr_q} + (CNT_W + 1)'(1);
	assign scan_more = ptr_q < count_q;
	assign ins_more  = ptr_q > pos_q;
	assign rem_more  = ptr_inc < {1'b0, count_q};
	assign has_room  = count_q < CNT_W'(CAPACITY);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = ptr_q[IDX_W-1:0];
		wr_data = rd_data_q;
		case (state_q)
			S_SCAN: begin
				rd_en = scan_more;
			end
			S_INS: begin
				if (ins_more) begin
					rd_en   = 1'b1;
					rd_addr = ptr_dec[IDX_W-1:0];
				end else begin
					wr_en   = 1'b1;
					wr_addr = pos_q[IDX_W-1:0];
					wr_data = value_q;
				end
			end
			S_INS_WR, S_REM_WR: begin
				wr_en = 1'b1;
			end
			S_REM: begin
				rd_en   = rem_more;
				rd_addr = ptr_inc[IDX_W-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			order_q <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			found_q <= 1'b0;
			ptr_q   <= '0;
			pos_q   <= '0;
			cmd_q   <= '0;
			value_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				order_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						value_q <= value;
						ptr_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_more) begin
						state_q <= S_CMP;
					end else begin
						found_q <= 1'b0;
						pos_q   <= ptr_q;
						state_q <= S_DECIDE;
					end
				end
				S_CMP: begin
					if (cmp_res.precedes) begin
						ptr_q   <= ptr_inc[CNT_W-1:0];
						state_q <= S_SCAN;
					end else begin
						found_q <= cmp_res.equal;
						pos_q   <= ptr_q;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					case (cmd_q)
						CMD_INSERT: begin
							ok_q <= has_room;
							if (has_room && !found_q) begin
								ptr_q   <= count_q;
								state_q <= S_INS;
							end else begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						CMD_REMOVE: begin
							ok_q <= found_q;
							if (found_q) begin
								ptr_q   <= pos_q;
								state_q <= S_REM;
							end else begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						default: begin
							ok_q    <= found_q;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_INS: begin
					if (ins_more) begin
						state_q <= S_INS_WR;
					end else begin
						count_q <= count_q + CNT_W'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_INS_WR: begin
					ptr_q   <= ptr_dec;
					state_q <= S_INS;
				end
				S_REM: begin
					if (rem_more) begin
						state_q <= S_REM_WR;
					end else begin
						count_q <= count_q - CNT_W'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_REM_WR: begin
					ptr_q   <= ptr_inc[CNT_W-1:0];
					state_q <= S_REM;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign pos_wide = 32'(pos_q);
	assign cnt_wide = 32'(count_q);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign done      = done_q;
	assign ok        = ok_q;
	assign present   = found_q;
	assign position  = pos_wide[FIELD_W-1:0];
	assign count     = cnt_wide[FIELD_W-1:0];

	`SLI_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SLI_ASSERT_NOW(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)
	`SLI_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy && !done_q)
	`SLI_ASSERT_NOW(a_count_on_done, clk, arst_n, !$stable(count_q), done_q && ok_q)

endmodule

`default_nettype wire
